// ===== design/cps_pkg.sv =====
`timescale 1ns / 1ps
// cps_pkg: shared types, constants and helpers of the credit priority scheduler
// depends on nothing; used by every other file of the block

package cps_pkg;

    // sizing
    localparam int MAX_PROCS    = 32;
    localparam int CREDIT_WIDTH = 16;

    localparam int ID_W    = 6;
    localparam int PRIO_W  = 6;
    localparam int CFG_W   = 8;
    localparam int PROD_W  = PRIO_W + CFG_W;
    localparam int WIDE_W  = ((CREDIT_WIDTH > PROD_W) ? CREDIT_WIDTH : PROD_W) + 1;
    localparam int CNT_W   = $clog2(MAX_PROCS + 1);

    // fixed widths of the result fields
    localparam int OUT_ID_W   = 5;
    localparam int OUT_CR_W   = 16;
    localparam int OUT_EV_W   = 3;
    localparam int OUT_LIVE_W = 6;

    localparam logic [WIDE_W-1:0] CREDIT_MAX =
        {{(WIDE_W - CREDIT_WIDTH){1'b0}}, {CREDIT_WIDTH{1'b1}}};

    // configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYBOARD_BONUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_BONUS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_BONUS     = 2'd3;

    localparam logic [CFG_W-1:0] RST_CREDIT_FACTOR  = 8'd20;
    localparam logic [CFG_W-1:0] RST_KEYBOARD_BONUS = 8'd100;
    localparam logic [CFG_W-1:0] RST_NETWORK_BONUS  = 8'd70;
    localparam logic [CFG_W-1:0] RST_DISK_BONUS     = 8'd20;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // step outcomes
    localparam logic [2:0] OC_TERMINATE = 3'd0;
    localparam logic [2:0] OC_YIELD     = 3'd1;
    localparam logic [2:0] OC_KEYBOARD  = 3'd2;
    localparam logic [2:0] OC_NETWORK   = 3'd3;
    localparam logic [2:0] OC_DISK      = 3'd4;

    typedef enum logic [OUT_EV_W-1:0] {
        EV_LOADED        = 3'd0,
        EV_IO            = 3'd1,
        EV_TERMINATED    = 3'd2,
        EV_REQUEUED      = 3'd3,
        EV_OUT_OF_CREDIT = 3'd4,
        EV_IDLE          = 3'd5,
        EV_FULL          = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RUN,
        ST_INSERT
    } state_t;

    typedef enum logic [1:0] {
        CHAIN_HOLD,
        CHAIN_INSERT,
        CHAIN_POP,
        CHAIN_RECHARGE
    } chain_op_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic [PRIO_W-1:0]       prio;
        logic [CREDIT_WIDTH-1:0] credits;
    } task_entry_t;

    // command broadcast from the sequencer to every cell of the row
    typedef struct packed {
        chain_op_t   op;
        task_entry_t entry;
        logic [CFG_W-1:0] factor;
    } chain_cmd_t;

    function automatic logic [CREDIT_WIDTH-1:0] sat_credit(input logic [WIDE_W-1:0] v);
        logic [CREDIT_WIDTH-1:0] r;
        if (v > CREDIT_MAX)
            r = {CREDIT_WIDTH{1'b1}};
        else
            r = v[CREDIT_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [OUT_CR_W-1:0] to_out_credits(
        input logic [CREDIT_WIDTH-1:0] c);
        logic [CREDIT_WIDTH+OUT_CR_W-1:0] t;
        t = {{OUT_CR_W{1'b0}}, c};
        return t[OUT_CR_W-1:0];
    endfunction

    function automatic logic [OUT_LIVE_W-1:0] to_out_live(input logic [CNT_W-1:0] n);
        logic [CNT_W+OUT_LIVE_W-1:0] t;
        t = {{OUT_LIVE_W{1'b0}}, n};
        return t[OUT_LIVE_W-1:0];
    endfunction

endpackage

// ===== design/cps_req_if.sv =====
`timescale 1ns / 1ps
// cps_req_if: request channel carrying one scheduler item
// depends on cps_pkg

interface cps_req_if
    import cps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [PRIO_W-1:0] task_priority;
    logic [2:0]        outcome;

    modport source (output valid, output opcode, output task_priority, output outcome,
                    input ready);
    modport sink   (input valid, input opcode, input task_priority, input outcome,
                    output ready);
endinterface

// ===== design/cps_rsp_if.sv =====
`timescale 1ns / 1ps
// cps_rsp_if: response channel carrying one scheduler result
// depends on cps_pkg

interface cps_rsp_if
    import cps_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OUT_ID_W-1:0]   task_id;
    logic [OUT_CR_W-1:0]   task_credits;
    logic [OUT_EV_W-1:0]   event_res;
    logic [OUT_LIVE_W-1:0] live_tasks;

    modport source (output valid, output task_id, output task_credits,
                    output event_res, output live_tasks, input ready);
    modport sink   (input valid, input task_id, input task_credits,
                    input event_res, input live_tasks, output ready);
endinterface

// ===== design/cps_cell.sv =====
`timescale 1ns / 1ps
// cps_cell: one slot of the sorted task row
// depends on cps_pkg; instantiated in a row by the top level

module cps_cell
    import cps_pkg::*;
(
    input  logic        clk,
    input  chain_cmd_t  cmd,
    input  logic        occupied,
    input  logic        left_go,
    input  task_entry_t left_entry,
    input  task_entry_t right_entry,
    output logic        go,
    output task_entry_t entry
);

    task_entry_t      entry_reg;
    task_entry_t      entry_next;
    logic [PROD_W-1:0] recharge_prod;

    // new item lands in the first slot that is free or holds fewer credits,
    // every slot behind it shifts one place right
    assign go    = left_go || !(occupied && (entry_reg.credits >= cmd.entry.credits));
    assign entry = entry_reg;

    assign recharge_prod = entry_reg.prio * cmd.factor;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CHAIN_INSERT:
            begin
                if (left_go)
                    entry_next = left_entry;
                else if (go)
                    entry_next = cmd.entry;
            end
            CHAIN_POP:
                entry_next = right_entry;
            CHAIN_RECHARGE:
                entry_next.credits = sat_credit(WIDE_W'(recharge_prod));
            CHAIN_HOLD:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/cps_ctrl.sv =====
`timescale 1ns / 1ps
// cps_ctrl: item sequencer, running task, counters, config registers and result register
// depends on cps_pkg, cps_req_if, cps_rsp_if; drives the cell row through chain_cmd_t

module cps_ctrl
    import cps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cps_req_if.sink              req,
    cps_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  task_entry_t          head,
    input  logic                 any_credit,
    output chain_cmd_t           cmd,
    output logic [CNT_W-1:0]     count
);

    state_t            state_reg, state_next;
    logic              op_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [2:0]        outcome_reg;

    logic              run_valid_reg, run_valid_next;
    task_entry_t       run_reg, run_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    task_entry_t       ins_reg, ins_next;
    event_t            ev_reg, ev_next;

    logic [CFG_W-1:0]  credit_factor_reg;
    logic [CFG_W-1:0]  keyboard_bonus_reg;
    logic [CFG_W-1:0]  network_bonus_reg;
    logic [CFG_W-1:0]  disk_bonus_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_ID_W-1:0]   out_id_reg, out_id_next;
    logic [OUT_CR_W-1:0]   out_cr_reg, out_cr_next;
    event_t                out_ev_reg, out_ev_next;
    logic [OUT_LIVE_W-1:0] out_live_reg, out_live_next;

    logic              emit_ok;
    logic              emit;
    logic [PRIO_W-1:0] mul_a;
    logic [CFG_W-1:0]  mul_b;
    logic [CFG_W-1:0]  bonus_sel;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  live_now;
    logic [CREDIT_WIDTH-1:0] dec_credits;
    logic [CREDIT_WIDTH-1:0] sat_prod;
    logic [CREDIT_WIDTH-1:0] io_credits;
    logic              no_credit_left;

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.task_id      = out_id_reg;
    assign rsp.task_credits = out_cr_reg;
    assign rsp.event_res    = out_ev_reg;
    assign rsp.live_tasks   = out_live_reg;
    assign count            = count_reg;

    assign emit_ok  = !out_valid_reg || rsp.ready;
    assign live_now = count_reg + CNT_W'(run_valid_reg);

    // shared multiplier: load credits, recharge of the running task, i/o bonus
    always_comb
    begin
        case (outcome_reg)
            OC_KEYBOARD: bonus_sel = keyboard_bonus_reg;
            OC_NETWORK:  bonus_sel = network_bonus_reg;
            default:     bonus_sel = disk_bonus_reg;
        endcase
    end

    assign mul_a = (state_reg == ST_DECIDE) ? prio_reg : run_reg.prio;
    assign mul_b = ((state_reg == ST_DECIDE) || (run_reg.credits == '0))
                   ? credit_factor_reg : bonus_sel;
    assign prod  = mul_a * mul_b;

    assign sat_prod       = sat_credit(WIDE_W'(prod));
    assign dec_credits    = run_reg.credits - CREDIT_WIDTH'(1);
    assign io_credits     = sat_credit(WIDE_W'(dec_credits) + WIDE_W'(prod));
    // a recharge leaves the row out of order, so every queued slot is checked
    assign no_credit_left = !any_credit;

    always_comb
    begin
        state_next     = state_reg;
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        ins_next       = ins_reg;
        ev_next        = ev_reg;
        emit           = 1'b0;
        out_id_next    = '0;
        out_cr_next    = '0;
        out_ev_next    = EV_IDLE;

        cmd.op     = CHAIN_HOLD;
        cmd.entry  = ins_reg;
        cmd.factor = credit_factor_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (emit_ok)
                begin
                    if (op_reg == OP_LOAD)
                    begin
                        if (live_now >= CNT_W'(MAX_PROCS))
                        begin
                            emit        = 1'b1;
                            out_ev_next = EV_FULL;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            ins_next     = '{id: next_id_reg, prio: prio_reg,
                                             credits: sat_prod};
                            next_id_next = next_id_reg + ID_W'(1);
                            ev_next      = EV_LOADED;
                            state_next   = ST_INSERT;
                        end
                    end
                    else if (!run_valid_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            emit        = 1'b1;
                            out_ev_next = EV_IDLE;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            run_next       = head;
                            run_valid_next = 1'b1;
                            count_next     = count_reg - CNT_W'(1);
                            cmd.op         = CHAIN_POP;
                            state_next     = ST_RUN;
                        end
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (emit_ok)
                begin
                    if (run_reg.credits == '0)
                    begin
                        ins_next = run_reg;
                        if (no_credit_left)
                        begin
                            ins_next.credits = sat_prod;
                            cmd.op           = CHAIN_RECHARGE;
                        end
                        run_valid_next = 1'b0;
                        ev_next        = EV_OUT_OF_CREDIT;
                        state_next     = ST_INSERT;
                    end
                    else
                    begin
                        case (outcome_reg) inside
                            OC_KEYBOARD, OC_NETWORK, OC_DISK:
                            begin
                                run_next.credits = io_credits;
                                emit             = 1'b1;
                                out_id_next      = run_reg.id[OUT_ID_W-1:0];
                                out_cr_next      = to_out_credits(io_credits);
                                out_ev_next      = EV_IO;
                                state_next       = ST_IDLE;
                            end
                            OC_TERMINATE:
                            begin
                                run_valid_next = 1'b0;
                                emit           = 1'b1;
                                out_id_next    = run_reg.id[OUT_ID_W-1:0];
                                out_cr_next    = to_out_credits(dec_credits);
                                out_ev_next    = EV_TERMINATED;
                                state_next     = ST_IDLE;
                            end
                            default:
                            begin
                                // yield, and the unused outcome codes
                                ins_next         = run_reg;
                                ins_next.credits = dec_credits;
                                run_valid_next   = 1'b0;
                                ev_next          = EV_REQUEUED;
                                state_next       = ST_INSERT;
                            end
                        endcase
                    end
                end
            end
            ST_INSERT:
            begin
                if (emit_ok)
                begin
                    cmd.op      = CHAIN_INSERT;
                    count_next  = count_reg + CNT_W'(1);
                    emit        = 1'b1;
                    out_id_next = ins_reg.id[OUT_ID_W-1:0];
                    out_cr_next = to_out_credits(ins_reg.credits);
                    out_ev_next = ev_reg;
                    state_next  = ST_IDLE;
                end
            end
        endcase

        out_live_next  = to_out_live(count_next + CNT_W'(run_valid_next));
        out_valid_next = out_valid_reg && !rsp.ready;
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_valid_reg <= 1'b0;
            run_reg       <= '0;
            count_reg     <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_valid_reg <= run_valid_next;
            run_reg       <= run_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg      <= req.opcode;
            prio_reg    <= req.task_priority;
            outcome_reg <= req.outcome;
        end
        ins_reg <= ins_next;
        ev_reg  <= ev_next;
        if (emit)
        begin
            out_id_reg   <= out_id_next;
            out_cr_reg   <= out_cr_next;
            out_ev_reg   <= out_ev_next;
            out_live_reg <= out_live_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_factor_reg  <= RST_CREDIT_FACTOR;
            keyboard_bonus_reg <= RST_KEYBOARD_BONUS;
            network_bonus_reg  <= RST_NETWORK_BONUS;
            disk_bonus_reg     <= RST_DISK_BONUS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CREDIT_FACTOR:  credit_factor_reg  <= cfg_wdata;
                CFG_KEYBOARD_BONUS: keyboard_bonus_reg <= cfg_wdata;
                CFG_NETWORK_BONUS:  network_bonus_reg  <= cfg_wdata;
                CFG_DISK_BONUS:     disk_bonus_reg     <= cfg_wdata;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCS))
        else $error("queued count beyond row length");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |-> (count_reg < CNT_W'(MAX_PROCS)))
        else $error("insert into a full row");

    a_run_has_task: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> run_valid_reg)
        else $error("run step without a running task");

    a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted item not taken to decode");
`endif

endmodule

// ===== design/credit_priority_scheduler_top.sv =====
`timescale 1ns / 1ps
// credit_priority_scheduler_top: top level, sequencer plus a row of task cells
// depends on cps_pkg, cps_req_if, cps_rsp_if, cps_cell, cps_ctrl

// Credit based priority scheduler. Waiting tasks sit in a row of MAX_PROCS
// cells kept sorted by credits, highest first, ties in arrival order; each
// cell holds one task and trades entries with its neighbors for a sorted
// insert, a pop of the head, or a recharge of every task (a recharge keeps
// the entries in place but can leave them out of credit order, so an insert
// after it lands in the first slot that holds fewer credits). A sequencer
// takes one item at a time: a load goes through decode with the credit
// multiply, then the insert into the row; a step goes through decode with
// an optional pop of the head, the credit update, and an insert when the
// task is requeued or out of credit; an idle step or a full table answers
// straight from decode. The next item is taken in the cycle after the
// result is written, and the sequencer issues one row operation at a time.
// A result waiting in the output register does not block the next transfer
// on the request channel; it only holds the sequencer until the register
// frees. Configuration is to be written by the user only while idle; the
// block itself does not enforce this.

module credit_priority_scheduler_top
    import cps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cps_req_if.sink              req,
    cps_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // broadcast command and row status
    chain_cmd_t        cmd;
    logic [CNT_W-1:0]  count;

    // per-cell wiring of the row
    task_entry_t          cell_entry [MAX_PROCS];
    logic [MAX_PROCS-1:0] cell_go;
    logic [MAX_PROCS-1:0] cell_occ;
    logic [MAX_PROCS-1:0] cell_credit;

    cps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .head       (cell_entry[0]),
        .any_credit (|cell_credit),
        .cmd        (cmd),
        .count      (count)
    );

    // the row: cell 0 is the head, entries shift right on insert, left on pop
    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        task_entry_t left_entry;
        task_entry_t right_entry;
        logic        left_go;

        // the first count cells hold queued tasks
        assign cell_occ[i] = (CNT_W'(i) < count);

        // a queued task that still has credit blocks the recharge
        assign cell_credit[i] = cell_occ[i] && (cell_entry[i].credits != '0);

        if (i == 0)
        begin : g_first
            assign left_go    = 1'b0;
            assign left_entry = cmd.entry;
        end
        else
        begin : g_inner
            assign left_go    = cell_go[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == MAX_PROCS - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        cps_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (cell_occ[i]),
            .left_go     (left_go),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .go          (cell_go[i]),
            .entry       (cell_entry[i])
        );
    end

endmodule
